// ----- rtl/tmru_pkg.sv -----
// ============================================================================
// tmru_pkg
// Shared types and constants of the triangular matrix row unpacker.
// ============================================================================
package tmru_pkg;

  localparam int MAX_VARS = 256;
  localparam int WORD_W   = 64;
  localparam int ROW_W    = 9;
  localparam int BUF_W    = 128;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 2;

  localparam logic [1:0] REG_NUM_VARS = 2'd0;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } q_head_t;

  typedef struct packed {
    logic [WORD_W-1:0] row_word;
    logic [ROW_W-1:0]  row_number;
    logic [IDX_W-1:0]  word_index;
    logic              row_end;
    logic              matrix_end;
    logic              constant_term;
  } result_t;

endpackage

// ----- rtl/tmru_in_queue.sv -----
// ============================================================================
// tmru_in_queue
// Two-entry input queue that takes stream words and hands them to the unpacker.
// ============================================================================
module tmru_in_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [tmru_pkg::WORD_W-1:0] push_word,
  output logic                     full,
  output tmru_pkg::q_head_t        head,
  input  logic                     pop
);
  import tmru_pkg::*;

  logic [WORD_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.word  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/tmru_unpack.sv -----
// ============================================================================
// tmru_unpack
// Realignment buffer, row counters: loads queued words, emits one aligned row
// word per cycle unless stalled or loading, into a registered output stage.
// ============================================================================
module tmru_unpack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tmru_pkg::q_head_t          head,
  output logic                       pop,
  input  logic [tmru_pkg::ROW_W-1:0] num_vars,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tmru_pkg::result_t          out_res
);
  import tmru_pkg::*;

  logic [BUF_W-1:0]  buf_r;
  logic [BUF_W-1:0]  buf_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [ROW_W-1:0]  done_r;
  logic [ROW_W-1:0]  done_nxt;
  logic              const_seen_r;
  logic              const_seen_nxt;
  logic              held_r;
  logic              held_nxt;
  logic              out_valid_r;
  result_t           out_res_r;

  logic [ROW_W-1:0]  n_eff;
  logic [ROW_W-1:0]  rem;
  logic [CNT_W-1:0]  chunk;
  logic              can_emit;
  logic              slot_free;
  logic              emit;
  logic              load;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] taken;
  logic [BUF_W-1:0]  appended;
  logic [ROW_W-1:0]  done_sum;
  logic              rend;
  logic              mend;

  always_comb begin
    priority if (num_vars == '0) begin
      n_eff = ROW_W'(1);
    end else if (num_vars > ROW_W'(MAX_VARS)) begin
      n_eff = ROW_W'(MAX_VARS);
    end else begin
      n_eff = num_vars;
    end
  end

  assign rem       = row_r - done_r;
  assign chunk     = (rem >= ROW_W'(WORD_W)) ? CNT_W'(WORD_W) : rem[CNT_W-1:0];
  assign can_emit  = (cnt_r >= chunk);
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = can_emit && slot_free;
  assign load      = !can_emit && head.valid;
  assign pop       = load;

  assign mask     = (chunk == CNT_W'(WORD_W)) ? '1
                  : ((WORD_W'(1) << chunk[5:0]) - WORD_W'(1));
  assign taken    = buf_r[WORD_W-1:0] & mask;
  assign appended = buf_r | ({{(BUF_W-WORD_W){1'b0}}, head.word} << cnt_r);
  assign done_sum = done_r + ROW_W'(chunk);
  assign rend     = (done_sum >= row_r);
  assign mend     = rend && (row_r >= n_eff);

  always_comb begin
    buf_nxt        = buf_r;
    cnt_nxt        = cnt_r;
    row_nxt        = row_r;
    done_nxt       = done_r;
    const_seen_nxt = const_seen_r;
    held_nxt       = held_r;
    if (emit) begin
      if (mend) begin
        buf_nxt        = '0;
        cnt_nxt        = '0;
        row_nxt        = ROW_W'(1);
        done_nxt       = '0;
        const_seen_nxt = 1'b0;
        held_nxt       = 1'b0;
      end else begin
        buf_nxt = buf_r >> chunk;
        cnt_nxt = cnt_r - chunk;
        if (rend) begin
          row_nxt  = row_r + ROW_W'(1);
          done_nxt = '0;
        end else begin
          done_nxt = done_sum;
        end
      end
    end else if (load) begin
      if (!const_seen_r) begin
        held_nxt       = appended[0];
        buf_nxt        = appended >> 1;
        cnt_nxt        = cnt_r + CNT_W'(WORD_W - 1);
        const_seen_nxt = 1'b1;
      end else begin
        buf_nxt = appended;
        cnt_nxt = cnt_r + CNT_W'(WORD_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r        <= '0;
      cnt_r        <= '0;
      row_r        <= ROW_W'(1);
      done_r       <= '0;
      const_seen_r <= 1'b0;
      held_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      buf_r        <= buf_nxt;
      cnt_r        <= cnt_nxt;
      row_r        <= row_nxt;
      done_r       <= done_nxt;
      const_seen_r <= const_seen_nxt;
      held_r       <= held_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r.row_word      <= taken;
      out_res_r.row_number    <= row_r;
      out_res_r.word_index    <= done_r[7:6];
      out_res_r.row_end       <= rend;
      out_res_r.matrix_end    <= mend;
      out_res_r.constant_term <= held_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef NO_ASSERTIONS
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r < CNT_W'(WORD_W)))
    else $error("word loaded with no room in the realignment buffer");

  a_row_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r >= ROW_W'(1)) && (done_r < row_r))
    else $error("row counters out of range");

  a_mend_rend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.matrix_end) |-> out_res_r.row_end)
    else $error("matrix end flagged on a word that does not end its row");
`endif

endmodule

// ----- rtl/triangular_matrix_row_unpacker.sv -----
// ============================================================================
// triangular_matrix_row_unpacker
// Unpacks a bit-packed lower triangular matrix stream into 64-bit aligned
// row words, with an APB-style register for the number of variables.
// ============================================================================
// The word that completes a result passes through the input queue, the buffer
// load and the output register before out_valid rises.
// The unpacker either loads an input word or emits a result word, never both
// at once.
// Reset clears the queue, buffer, row counters and output valid flag and sets
// num_vars to 256.
// ============================================================================
module triangular_matrix_row_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_packed_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_row_word,
  output logic [8:0]  out_row_number,
  output logic [1:0]  out_word_index,
  output logic        out_row_end,
  output logic        out_matrix_end,
  output logic        out_constant_term,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmru_pkg::*;

  logic [ROW_W-1:0] num_vars_r;
  logic             q_full;
  logic             q_pop;
  q_head_t          q_head;
  result_t          res;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_NUM_VARS) ? {{(32-ROW_W){1'b0}}, num_vars_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= ROW_W'(MAX_VARS);
    end else if (cfg_wr) begin
      num_vars_r <= pwdata[ROW_W-1:0];
    end
  end

  assign in_stall = q_full;

  tmru_in_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (in_packed_word),
    .full      (q_full),
    .head      (q_head),
    .pop       (q_pop)
  );

  tmru_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .num_vars  (num_vars_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_row_word      = res.row_word;
  assign out_row_number    = res.row_number;
  assign out_word_index    = res.word_index;
  assign out_row_end       = res.row_end;
  assign out_matrix_end    = res.matrix_end;
  assign out_constant_term = res.constant_term;

endmodule
